@@ hw/rtl/iirc_pkg.sv @@
// Shared types and constants of the I/O interrupt redirection controller.
package iirc_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RAISE = 2'd2,
        FUNC_EOI   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    localparam logic [7:0] OFF_SELECT   = 8'h00;
    localparam logic [7:0] OFF_WINDOW   = 8'h10;
    localparam logic [7:0] IDX_ID       = 8'h00;
    localparam logic [7:0] IDX_VER      = 8'h01;
    localparam logic [7:0] IDX_ARB      = 8'h02;
    localparam logic [7:0] IDX_TABLE    = 8'h10;
    localparam logic [7:0] VERSION_CODE = 8'h11;

    localparam int BIT_REMOTE_IRR = 14;
    localparam int BIT_LEVEL      = 15;
    localparam int BIT_MASK       = 16;
    localparam int DELMODE_LSB    = 8;
    localparam int DELMODE_MSB    = 10;

    localparam logic [31:0] LOW_KEEP    = 32'h0000_5000;
    localparam logic [63:0] ENTRY_RESET = 64'h0000_0000_0001_0000;
    localparam logic [63:0] IRR_SET     = 64'h0000_0000_0000_4000;

endpackage

@@ hw/rtl/io_interrupt_redirection_controller.sv @@
// Top level of the I/O interrupt redirection controller.
// Flow: select, ID/version and other out-of-table window items, bad-offset items and
// out-of-range raises go from ST_IDLE straight to ST_DONE; table reads, writes and raises pass
// ST_LOOK (entry read, then write-back); an EOI passes ST_SCAN, which walks the entry memory per
// entry. One item at a time: s_tready stays low until ST_DONE loads the result and sets m_tvalid.
// Reset clears index select, unit ID and entry valid bits; unwritten entries read as masked.
module io_interrupt_redirection_controller #(
    parameter int NUM_ENTRIES = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iirc_pkg::S_TDATA_W-1:0] s_tdata,  // offset, write_data, line, eoi_vector
    input  logic [iirc_pkg::S_TUSER_W-1:0] s_tuser,  // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iirc_pkg::M_TDATA_W-1:0] m_tdata   // read_data, status, delivered, vector_out
);
    import iirc_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [8:0] TABLE_END = 9'(IDX_TABLE) + 9'(2 * NUM_ENTRIES);
    localparam logic [8:0] NUM_ENT9 = 9'(NUM_ENTRIES);
    localparam logic [7:0] VER_MAX = 8'(NUM_ENTRIES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    func_t       in_func;
    logic [7:0]  in_offset;
    logic [31:0] in_wdata;
    logic [7:0]  in_line;
    logic [7:0]  in_eoi;

    state_t      state_reg, state_next;
    logic [7:0]  index_select_reg, index_select_next;
    logic [3:0]  unit_id_reg, unit_id_next;
    func_t       func_reg;
    logic [31:0] wdata_reg;
    logic [7:0]  eoi_reg;
    logic        high_reg;
    logic [IDX_W-1:0] slot_reg, slot_next;

    logic [31:0] res_rdata_reg, res_rdata_next;
    logic        res_status_reg, res_status_next;
    logic        res_deliv_reg, res_deliv_next;
    logic [7:0]  res_vec_reg, res_vec_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 load_out;

    logic [63:0]      mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [63:0]      wr_data;
    logic [63:0]      rd_data_reg;
    logic             rd_valid_reg;
    logic [63:0]      entry;

    logic [7:0]       win_rel;
    logic             win_in_table;
    logic [IDX_W-1:0] win_slot;
    logic             line_ok;
    logic             accept;
    logic             raise_ok;

    assign in_func   = func_t'(s_tuser);
    assign in_offset = s_tdata[7:0];
    assign in_wdata  = s_tdata[39:8];
    assign in_line   = s_tdata[47:40];
    assign in_eoi    = s_tdata[55:48];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign win_rel      = index_select_reg - IDX_TABLE;
    assign win_in_table = ({1'b0, index_select_reg} >= 9'(IDX_TABLE)) &&
                          ({1'b0, index_select_reg} < TABLE_END);
    assign win_slot     = IDX_W'(win_rel[7:1]);
    assign line_ok      = {1'b0, in_line} < NUM_ENT9;

    assign entry    = rd_valid_reg ? rd_data_reg : ENTRY_RESET;
    assign raise_ok = !entry[BIT_MASK] && (entry[DELMODE_MSB:DELMODE_LSB] == 3'd0) &&
                      !(entry[BIT_LEVEL] && entry[BIT_REMOTE_IRR]);

    always_comb begin
        state_next        = state_reg;
        index_select_next = index_select_reg;
        unit_id_next      = unit_id_reg;
        res_rdata_next    = res_rdata_reg;
        res_status_next   = res_status_reg;
        res_deliv_next    = res_deliv_reg;
        res_vec_next      = res_vec_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = slot_reg;
        wr_data           = entry;
        load_out          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_rdata_next  = '0;
                    res_status_next = 1'b0;
                    res_deliv_next  = 1'b0;
                    res_vec_next    = '0;
                    state_next      = ST_DONE;
                    unique case (in_func) inside
                        FUNC_READ, FUNC_WRITE: begin
                            if (in_offset == OFF_SELECT) begin
                                if (in_func == FUNC_READ) begin
                                    res_rdata_next = {24'd0, index_select_reg};
                                end else begin
                                    index_select_next = in_wdata[7:0];
                                end
                            end else if (in_offset == OFF_WINDOW) begin
                                if (win_in_table) begin
                                    rd_en      = 1'b1;
                                    rd_addr    = win_slot;
                                    state_next = ST_LOOK;
                                end else if (in_func == FUNC_READ) begin
                                    if (index_select_reg == IDX_ID ||
                                        index_select_reg == IDX_ARB) begin
                                        res_rdata_next = {4'd0, unit_id_reg, 24'd0};
                                    end else if (index_select_reg == IDX_VER) begin
                                        res_rdata_next = {8'd0, VER_MAX, 8'd0, VERSION_CODE};
                                    end
                                end else if (index_select_reg == IDX_ID) begin
                                    unit_id_next = in_wdata[27:24];
                                end
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        FUNC_RAISE: begin
                            if (line_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(in_line);
                                state_next = ST_LOOK;
                            end
                        end
                        default: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                state_next = ST_DONE;
                unique case (func_reg)
                    FUNC_READ: begin
                        res_rdata_next = high_reg ? entry[63:32] : entry[31:0];
                    end
                    FUNC_WRITE: begin
                        wr_en = 1'b1;
                        if (high_reg) begin
                            wr_data = {wdata_reg, entry[31:0]};
                        end else begin
                            wr_data = {entry[63:32],
                                       (wdata_reg & ~LOW_KEEP) | (entry[31:0] & LOW_KEEP)};
                        end
                    end
                    FUNC_RAISE: begin
                        if (raise_ok) begin
                            res_deliv_next = 1'b1;
                            res_vec_next   = entry[7:0];
                            if (entry[BIT_LEVEL]) begin
                                wr_en   = 1'b1;
                                wr_data = entry | IRR_SET;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                if (entry[BIT_LEVEL] && entry[BIT_REMOTE_IRR] && (entry[7:0] == eoi_reg)) begin
                    wr_en   = 1'b1;
                    wr_data = entry & ~IRR_SET;
                end
                if (slot_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = slot_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot_next = rd_en ? rd_addr : slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            index_select_reg <= '0;
            unit_id_reg      <= '0;
            valid_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            index_select_reg <= index_select_next;
            unit_id_reg      <= unit_id_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= in_func;
            wdata_reg <= in_wdata;
            eoi_reg   <= in_eoi;
            high_reg  <= win_rel[0];
        end
        slot_reg       <= slot_next;
        res_rdata_reg  <= res_rdata_next;
        res_status_reg <= res_status_next;
        res_deliv_reg  <= res_deliv_next;
        res_vec_reg    <= res_vec_next;
        if (load_out) begin
            m_tdata_reg <= {6'd0, res_vec_reg, res_deliv_reg, res_status_reg, res_rdata_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

endmodule

@@ hw/rtl/iirc_checker.sv @@
// Port-level assertions for the I/O interrupt redirection controller, bound to the top level.
module iirc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [iirc_pkg::M_TDATA_W-1:0] m_tdata
);
    import iirc_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    a_no_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[33] |-> m_tdata[41:34] == 8'd0)
        else $error("vector shown without delivery");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && !m_tdata[33])
        else $error("error status with data or delivery");

    a_deliv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> m_tdata[31:0] == 32'd0 && m_tdata[47:42] == 6'd0)
        else $error("delivery with read data or stray bits");

endmodule

bind io_interrupt_redirection_controller iirc_checker u_iirc_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the I/O interrupt redirection controller.
module tb_top;
    import iirc_pkg::*;

    localparam int N_ENTRIES   = 24;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] rdata;
        logic        status;
        logic        delivered;
        logic [7:0]  vec;
    } irq_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // offset, write_data, line, eoi_vector
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // read_data, status, delivered, vector_out

    // predictor state
    logic [7:0]  sel_reg;
    logic [3:0]  id_reg;
    logic [63:0] entry_mem [N_ENTRIES];

    irq_result_t expected_q [$];
    int          items_sent   = 0;
    int          fail_cnt     = 0;
    int          cycle_cnt    = 0;
    int          src_idle_pct = 9;
    int          snk_idle_pct = 84;
    logic        hold_on      = 1'b0;
    event        hold_go;

    io_interrupt_redirection_controller #(
        .NUM_ENTRIES(N_ENTRIES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial forever #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL io_interrupt_redirection_controller");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_on) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial forever begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    function automatic irq_result_t predict_item(func_t f, logic [7:0] off, logic [31:0] wd,
                                                 logic [7:0] ln, logic [7:0] ev);
        irq_result_t r;
        logic [63:0] e;
        logic        in_table;
        logic        ok;
        int          n;
        r        = '0;
        in_table = (sel_reg >= IDX_TABLE) && (int'(sel_reg) < int'(IDX_TABLE) + 2 * N_ENTRIES);
        n        = (int'(sel_reg) - int'(IDX_TABLE)) >>> 1;
        case (f) inside
            FUNC_READ, FUNC_WRITE: begin
                if (off == OFF_SELECT) begin
                    if (f == FUNC_READ) r.rdata = {24'b0, sel_reg};
                    else sel_reg = wd[7:0];
                end else if (off == OFF_WINDOW) begin
                    if (f == FUNC_READ) begin
                        if (sel_reg == IDX_ID || sel_reg == IDX_ARB) begin
                            r.rdata = {4'b0, id_reg, 24'b0};
                        end else if (sel_reg == IDX_VER) begin
                            r.rdata = {8'b0, 8'(N_ENTRIES - 1), 8'b0, VERSION_CODE};
                        end else if (in_table) begin
                            r.rdata = sel_reg[0] ? entry_mem[n][63:32] : entry_mem[n][31:0];
                        end
                    end else begin
                        if (sel_reg == IDX_ID) begin
                            id_reg = wd[27:24];
                        end else if (in_table) begin
                            if (sel_reg[0]) entry_mem[n][63:32] = wd;
                            else entry_mem[n][31:0] = (wd & ~LOW_KEEP) |
                                                      (entry_mem[n][31:0] & LOW_KEEP);
                        end
                    end
                end else begin
                    r.status = 1'b1;
                end
            end
            FUNC_RAISE: begin
                if (ln < N_ENTRIES) begin
                    e  = entry_mem[ln];
                    ok = !e[BIT_MASK] && (e[DELMODE_MSB:DELMODE_LSB] == 3'd0);
                    if (ok && e[BIT_LEVEL]) begin
                        if (e[BIT_REMOTE_IRR]) ok = 1'b0;
                        else entry_mem[ln] = e | IRR_SET;
                    end
                    if (ok) begin
                        r.delivered = 1'b1;
                        r.vec       = e[7:0];
                    end
                end
            end
            default: begin
                for (int i = 0; i < N_ENTRIES; i++) begin
                    if (entry_mem[i][BIT_LEVEL] && entry_mem[i][BIT_REMOTE_IRR] &&
                        entry_mem[i][7:0] == ev)
                        entry_mem[i][BIT_REMOTE_IRR] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_vector();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h41;
            3: return 8'h42;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(func_t f, logic [7:0] off, logic [31:0] wd,
                             logic [7:0] ln, logic [7:0] ev);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ev, ln, wd, off};
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_item(f, off, wd, ln, ev));
        items_sent++;
    endtask

    task automatic select_index(logic [7:0] idx);
        send_item(FUNC_WRITE, OFF_SELECT, ($urandom & 32'hFFFF_FF00) | idx,
                  8'($urandom), 8'($urandom));
    endtask

    task automatic window_access(func_t f, logic [31:0] wd);
        send_item(f, OFF_WINDOW, wd, 8'($urandom), 8'($urandom));
    endtask

    task automatic raise_line(logic [7:0] ln);
        send_item(FUNC_RAISE, 8'($urandom), $urandom, ln, 8'($urandom));
    endtask

    task automatic end_of_irq(logic [7:0] ev);
        send_item(FUNC_EOI, 8'($urandom), $urandom, 8'($urandom), ev);
    endtask

    task automatic test_id_and_version();
        send_item(FUNC_READ, OFF_SELECT, 32'h0, 8'h0, 8'h0);
        window_access(FUNC_READ, 32'h0);
        window_access(FUNC_WRITE, 32'hFFFF_FFFF);
        window_access(FUNC_READ, 32'h0);
        select_index(IDX_VER);
        window_access(FUNC_WRITE, 32'hFFFF_FFFF);
        window_access(FUNC_READ, 32'h0);
        select_index(IDX_ARB);
        window_access(FUNC_WRITE, 32'h0);
        window_access(FUNC_READ, 32'h0);
    endtask

    task automatic test_unmapped_and_bad_offset();
        select_index(8'h0F);
        window_access(FUNC_WRITE, 32'hFFFF_FFFF);
        window_access(FUNC_READ, 32'h0);
        send_item(FUNC_READ, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(FUNC_WRITE, 8'h01, 32'hFFFF_FFFF, 8'h00, 8'h00);
    endtask

    task automatic test_table_halves();
        select_index(IDX_TABLE);
        window_access(FUNC_WRITE, 32'hFFFF_FFFF);
        window_access(FUNC_READ, 32'h0);
        select_index(8'(int'(IDX_TABLE) + 2 * N_ENTRIES - 1));
        window_access(FUNC_WRITE, 32'hFFFF_FFFF);
        window_access(FUNC_READ, 32'h0);
    endtask

    task automatic test_raise_cases();
        raise_line(8'(N_ENTRIES));
        raise_line(8'hFF);
        raise_line(8'd0);
        select_index(IDX_TABLE + 8'd4);
        window_access(FUNC_WRITE, 32'h0000_0000);
        raise_line(8'd2);
        select_index(IDX_TABLE + 8'd8);
        window_access(FUNC_WRITE, 32'h0000_0320);
        raise_line(8'd4);
    endtask

    task automatic test_level_eoi();
        select_index(IDX_TABLE + 8'd6);
        window_access(FUNC_WRITE, 32'h0000_80FF);
        raise_line(8'd3);
        raise_line(8'd3);
        window_access(FUNC_WRITE, 32'h0000_80FF);
        window_access(FUNC_READ, 32'h0);
        end_of_irq(8'h7F);
        raise_line(8'd3);
        end_of_irq(8'hFF);
        raise_line(8'd3);
    endtask

    task automatic test_random_traffic(int count);
        int          target;
        int          pick;
        int          n;
        logic [31:0] lo;
        logic [7:0]  idx;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_item(func_t'($urandom_range(0, 3)),
                          ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                          ($urandom_range(0, 1) ? OFF_SELECT : OFF_WINDOW),
                          $urandom, 8'($urandom), 8'($urandom));
            end else if (pick < 40) begin
                n      = $urandom_range(0, N_ENTRIES - 1);
                lo     = $urandom;
                lo[7:0] = pick_vector();
                if ($urandom_range(0, 7) != 0) lo[DELMODE_MSB:DELMODE_LSB] = 3'd0;
                lo[BIT_MASK] = ($urandom_range(0, 5) == 0);
                select_index(8'(int'(IDX_TABLE) + 2 * n));
                window_access(FUNC_WRITE, lo);
                if ($urandom_range(0, 3) == 0) window_access(FUNC_READ, $urandom);
                if ($urandom_range(0, 3) == 0) begin
                    select_index(8'(int'(IDX_TABLE) + 2 * n + 1));
                    window_access(FUNC_WRITE, $urandom);
                end
            end else if (pick < 75) begin
                raise_line(($urandom_range(0, 15) == 0) ? 8'($urandom) :
                           8'($urandom_range(0, N_ENTRIES - 1)));
            end else if (pick < 88) begin
                end_of_irq($urandom_range(0, 1) ?
                           entry_mem[$urandom_range(0, N_ENTRIES - 1)][7:0] : pick_vector());
            end else begin
                idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                      8'($urandom_range(0, int'(IDX_TABLE) + 2 * N_ENTRIES));
                select_index(idx);
                window_access(FUNC_READ, $urandom);
                if ($urandom_range(0, 3) == 0) window_access(FUNC_WRITE, $urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        -> hold_go;
        test_random_traffic(40);
    endtask

    always @(posedge aclk) begin : check_results
        irq_result_t want;
        irq_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = irq_result_t'({m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[41:34]});
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got.rdata !== want.rdata) begin
                    $display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
                    fail_cnt++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %h actual %h", $time, want.status, got.status);
                    fail_cnt++;
                end
                if (got.delivered !== want.delivered) begin
                    $display("%0t: delivered expected %h actual %h", $time,
                             want.delivered, got.delivered);
                    fail_cnt++;
                end
                if (got.vec !== want.vec) begin
                    $display("%0t: vector_out expected %h actual %h", $time, want.vec, got.vec);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        sel_reg = '0;
        id_reg  = '0;
        foreach (entry_mem[i]) entry_mem[i] = ENTRY_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_id_and_version();
        test_unmapped_and_bad_offset();
        test_table_halves();
        test_raise_cases();
        test_level_eoi();
        test_random_traffic(600);
        src_idle_pct = 84;
        snk_idle_pct = 9;
        test_random_traffic(600);
        test_backpressure();
        test_random_traffic(560);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (N_ENTRIES + 8) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("PASS io_interrupt_redirection_controller");
        end else begin
            $display("FAIL io_interrupt_redirection_controller");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/iirc_pkg.sv
hw/rtl/io_interrupt_redirection_controller.sv
hw/rtl/iirc_checker.sv
tb/sv/tb_top.sv
